// ===== rtl/core/lfu_lru_pkg.sv =====
package lfu_lru_pkg;

   localparam int CAPACITY    = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int DATA_W      = 32;
   localparam int CFG_W       = 5;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (FILL_W > CFG_W) ? FILL_W : CFG_W;

   localparam logic [CFG_W-1:0]       CAP_RESET = CFG_W'(16);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

// ===== rtl/core/lfu_cache_lru_tiebreak.sv =====
// Key-value cache of CAPACITY entries with least-frequently-used replacement,
// ties going to the least recently used entry. Each request beat carries a get
// or a put and produces exactly one response beat. A request is registered,
// then scanned one entry at a time through a single key and victim comparator,
// then finished in an update cycle that writes the entry and adjusts all recency
// ranks at once, after any waiting response has been taken. The request side is
// not ready during the scan and update; a response waiting in the output
// register does not hold off the next request until its update cycle. Writes
// to the capacity register are taken in any cycle and should be made while idle.
module lfu_cache_lru_tiebreak (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: key[31:0], value[63:32].
   input  logic [2*lfu_lru_pkg::DATA_W-1:0]    req_tdata,
   // Fields from bit 0: op.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: read_value[31:0], evicted_key[63:32].
   output logic [2*lfu_lru_pkg::DATA_W-1:0]    rsp_tdata,
   // Fields from bit 0: hit, evicted.
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [lfu_lru_pkg::CFG_W-1:0]       csr_wr_data
);
   import lfu_lru_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] cap_ff, cap_in;

   logic                   valid_ff [CAPACITY];
   logic                   valid_in [CAPACITY];
   logic [DATA_W-1:0]      key_ff   [CAPACITY];
   logic [DATA_W-1:0]      key_in   [CAPACITY];
   logic [DATA_W-1:0]      data_ff  [CAPACITY];
   logic [DATA_W-1:0]      data_in  [CAPACITY];
   logic [COUNT_WIDTH-1:0] count_ff [CAPACITY];
   logic [COUNT_WIDTH-1:0] count_in [CAPACITY];
   logic [IDX_W-1:0]       rank_ff  [CAPACITY];
   logic [IDX_W-1:0]       rank_in  [CAPACITY];

   logic              op_ff, op_in;
   logic [DATA_W-1:0] req_key_ff, req_key_in;
   logic [DATA_W-1:0] req_value_ff, req_value_in;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       found_idx_ff, found_idx_in;
   logic [DATA_W-1:0]      found_data_ff, found_data_in;
   logic [COUNT_WIDTH-1:0] found_count_ff, found_count_in;
   logic [IDX_W-1:0]       found_rank_ff, found_rank_in;

   logic                   vic_ff, vic_in;
   logic [IDX_W-1:0]       vic_idx_ff, vic_idx_in;
   logic [COUNT_WIDTH-1:0] vic_count_ff, vic_count_in;
   logic [IDX_W-1:0]       vic_rank_ff, vic_rank_in;
   logic [DATA_W-1:0]      vic_key_ff, vic_key_in;

   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic [DATA_W-1:0] rsp_evkey_ff, rsp_evkey_in;

   logic                   req_fire;
   logic                   scan_last;
   logic                   e_valid;
   logic [DATA_W-1:0]      e_key;
   logic [COUNT_WIDTH-1:0] e_count;
   logic [IDX_W-1:0]       e_rank;
   logic                   vic_better;
   logic                   commit;
   logic [CMP_W-1:0]       cap_eff;
   logic                   cap_zero;
   logic                   do_touch;
   logic                   do_insert;
   logic                   do_evict;
   logic [IDX_W-1:0]       slot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_last  = (idx_ff == IDX_W'(CAPACITY - 1));
   assign commit     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   assign e_valid = valid_ff[idx_ff];
   assign e_key   = key_ff[idx_ff];
   assign e_count = count_ff[idx_ff];
   assign e_rank  = rank_ff[idx_ff];
   assign vic_better = !vic_ff || (e_count < vic_count_ff) ||
                       ((e_count == vic_count_ff) && (e_rank > vic_rank_ff));

   assign cap_eff   = (CMP_W'(cap_ff) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_ff);
   assign cap_zero  = (cap_ff == '0);
   assign do_touch  = found_ff && ((op_ff == OP_GET) || !cap_zero);
   assign do_insert = (op_ff == OP_PUT) && !cap_zero && !found_ff;
   assign do_evict  = do_insert && vic_ff && (CMP_W'(fill_ff) >= cap_eff);
   assign slot      = do_evict ? vic_idx_ff : free_idx_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      req_key_in   = req_key_ff;
      req_value_in = req_value_ff;
      fill_in      = fill_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_data_in  = found_data_ff;
      found_count_in = found_count_ff;
      found_rank_in  = found_rank_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_count_in = vic_count_ff;
      vic_rank_in  = vic_rank_ff;
      vic_key_in   = vic_key_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in        = req_tuser;
               req_key_in   = req_tdata[DATA_W-1:0];
               req_value_in = req_tdata[2*DATA_W-1:DATA_W];
               idx_in       = '0;
               fill_in      = '0;
               found_in     = 1'b0;
               vic_in       = 1'b0;
               free_in      = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (e_valid) begin
               fill_in = fill_ff + FILL_W'(1);
               if (!found_ff && (e_key == req_key_ff)) begin
                  found_in       = 1'b1;
                  found_idx_in   = idx_ff;
                  found_data_in  = data_ff[idx_ff];
                  found_count_in = e_count;
                  found_rank_in  = e_rank;
               end
               if (vic_better) begin
                  vic_in       = 1'b1;
                  vic_idx_in   = idx_ff;
                  vic_count_in = e_count;
                  vic_rank_in  = e_rank;
                  vic_key_in   = e_key;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         valid_in[j] = valid_ff[j];
         key_in[j]   = key_ff[j];
         data_in[j]  = data_ff[j];
         count_in[j] = count_ff[j];
         rank_in[j]  = rank_ff[j];
         if (commit && do_touch) begin
            if (IDX_W'(j) == found_idx_ff) begin
               rank_in[j] = '0;
               if (found_count_ff != COUNT_MAX) begin
                  count_in[j] = found_count_ff + COUNT_ONE;
               end
               if (op_ff == OP_PUT) begin
                  data_in[j] = req_value_ff;
               end
            end else if (valid_ff[j] && (rank_ff[j] < found_rank_ff)) begin
               rank_in[j] = rank_ff[j] + IDX_W'(1);
            end
         end
         if (commit && do_insert && (do_evict || free_ff)) begin
            if (IDX_W'(j) == slot) begin
               valid_in[j] = 1'b1;
               key_in[j]   = req_key_ff;
               data_in[j]  = req_value_ff;
               count_in[j] = COUNT_ONE;
               rank_in[j]  = '0;
            end else if (valid_ff[j]) begin
               if (do_evict && (rank_ff[j] > vic_rank_ff)) begin
                  rank_in[j] = rank_ff[j];
               end else begin
                  rank_in[j] = rank_ff[j] + IDX_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_evkey_in   = rsp_evkey_ff;
      if (commit) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = do_touch;
         rsp_evicted_in = do_evict;
         rsp_read_in    = (found_ff && (op_ff == OP_GET)) ? found_data_ff : '0;
         rsp_evkey_in   = do_evict ? vic_key_ff : '0;
      end
   end

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < CAPACITY; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < CAPACITY; j++) begin
            valid_ff[j] <= valid_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         key_ff[j]   <= key_in[j];
         data_ff[j]  <= data_in[j];
         count_ff[j] <= count_in[j];
         rank_ff[j]  <= rank_in[j];
      end
      op_ff          <= op_in;
      req_key_ff     <= req_key_in;
      req_value_ff   <= req_value_in;
      idx_ff         <= idx_in;
      fill_ff        <= fill_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_data_ff  <= found_data_in;
      found_count_ff <= found_count_in;
      found_rank_ff  <= found_rank_in;
      vic_ff         <= vic_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
      vic_key_ff     <= vic_key_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_evkey_ff, rsp_read_ff};
   assign rsp_tuser  = {rsp_evicted_ff, rsp_hit_ff};

endmodule

// ===== rtl/core/lfu_lru_checker.sv =====
module lfu_lru_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A request beat closes the request side while it is being worked on.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side ready right after a request beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

   // A put that evicts never also reports a hit.
   a_hit_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("response reports both hit and eviction");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("read value nonzero on a miss");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfu_lru_checker u_lfu_lru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
